### rtl/let_pkg.sv
// Shared types and constants for the level episode tracker.
// Used by every module of the block; depends on nothing.
package let_pkg;

    localparam int LEVEL_W   = 12;
    localparam int POS_OUT_W = 15;
    localparam int CNT_W     = 14;
    localparam int CAT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 64;

    localparam logic [CNT_W-1:0]   COUNT_LIMIT       = 14'd8192;
    localparam logic [LEVEL_W-1:0] FLOOD_RESET       = 12'd800;
    localparam logic [LEVEL_W-1:0] ALERT_TWO_RESET   = 12'd900;
    localparam logic [LEVEL_W-1:0] ALERT_THREE_RESET = 12'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLOOD       = 2'd0,
        REG_ALERT_TWO   = 2'd1,
        REG_ALERT_THREE = 2'd2
    } cfg_index_t;

    typedef enum logic [CAT_W-1:0] {
        CAT_NONE  = 2'd0,
        CAT_ONE   = 2'd1,
        CAT_TWO   = 2'd2,
        CAT_THREE = 2'd3
    } category_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] flood_threshold;
        logic [LEVEL_W-1:0] alert_two_threshold;
        logic [LEVEL_W-1:0] alert_three_threshold;
    } cfg_t;

    typedef struct packed {
        logic                 episode_valid;
        logic [POS_OUT_W-1:0] start_position;
        logic [POS_OUT_W-1:0] end_position;
        logic                 category_dropped;
        logic [CNT_W-1:0]     episode_total;
        logic [CNT_W-1:0]     drop_episode_total;
        logic                 sequence_done;
    } result_t;

    function automatic category_t level_category(input logic [LEVEL_W-1:0] level,
                                                 input cfg_t cfg);
        category_t cat;
        if (level <= cfg.flood_threshold) begin
            cat = CAT_NONE;
        end
        else if (level < cfg.alert_two_threshold) begin
            cat = CAT_ONE;
        end
        else if (level < cfg.alert_three_threshold) begin
            cat = CAT_TWO;
        end
        else begin
            cat = CAT_THREE;
        end
        return cat;
    endfunction

endpackage

### rtl/level_episode_tracker.sv
// Level episode tracker: one water-level sample per input transfer, one transfer per
// cycle sustained while no back-pressure holds the input. Each sample passes an input
// register, the episode update logic and a result register, which takes the result
// when its sample leaves the input register. A sample that closes no episode and is
// not last yields no output. The result register lets a new sample in while a finished
// result waits; back-pressure reaches the input only when a result-producing sample
// meets a full, stalled result register. Thresholds are written through the cfg
// channel (always ready), by the user only while the block is idle; nothing enforces it.
// Depends on let_pkg, let_cfg_regs and let_episode_core.
module level_episode_tracker #(
    parameter int MAX_SAMPLES = 16384
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [let_pkg::TDATA_IN_W-1:0]    s_axis_tdata,  // [11:0] sample_level
    input  logic                              s_axis_tlast,  // last_sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [14:0] start_position, [29:15] end_position, [30] category_dropped,
    // [44:31] episode_total, [58:45] drop_episode_total, zero above
    output logic [let_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser,  // episode_valid
    output logic                              m_axis_tlast,  // sequence_done
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [let_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [let_pkg::LEVEL_W-1:0]       cfg_data
);
    import let_pkg::*;

    cfg_t               cfg;
    logic               in_valid_reg, in_valid_next;
    logic [LEVEL_W-1:0] in_level_reg;
    logic               in_last_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;
    result_t            result;
    logic               has_result;
    logic               out_free;
    logic               advance;
    logic               in_take;

    let_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    let_episode_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .advance    (advance),
        .level      (in_level_reg),
        .last       (in_last_reg),
        .has_result (has_result),
        .result     (result)
    );

    assign cfg_ready = 1'b1;

    // a sample with no result may pass even while the result register stalls
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (out_free || !has_result);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_level_reg <= s_axis_tdata[LEVEL_W-1:0];
            in_last_reg  <= s_axis_tlast;
        end
        if (advance && has_result)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.episode_valid;
    assign m_axis_tlast  = out_reg.sequence_done;
    assign m_axis_tdata  = {5'b0,
                            out_reg.drop_episode_total,
                            out_reg.episode_total,
                            out_reg.category_dropped,
                            out_reg.end_position,
                            out_reg.start_position};

endmodule

### rtl/let_cfg_regs.sv
// Threshold registers of the level episode tracker, written over the config channel.
// Depends on let_pkg.
module let_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [let_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [let_pkg::LEVEL_W-1:0]   cfg_data,
    output let_pkg::cfg_t                 cfg
);
    import let_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FLOOD:       cfg_next.flood_threshold       = cfg_data;
                REG_ALERT_TWO:   cfg_next.alert_two_threshold   = cfg_data;
                REG_ALERT_THREE: cfg_next.alert_three_threshold = cfg_data;
                default:         cfg_next = cfg_reg; // unused index: drop the write
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flood_threshold       <= FLOOD_RESET;
            cfg_reg.alert_two_threshold   <= ALERT_TWO_RESET;
            cfg_reg.alert_three_threshold <= ALERT_THREE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/let_episode_core.sv
// Episode state and per-sample update: categorises one registered sample,
// tracks the open episode and builds the result. Depends on let_pkg.
module let_episode_core #(
    parameter int MAX_SAMPLES = 16384
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  let_pkg::cfg_t               cfg,
    input  logic                        advance,
    input  logic [let_pkg::LEVEL_W-1:0] level,
    input  logic                        last,
    output logic                        has_result,
    output let_pkg::result_t            result
);
    import let_pkg::*;

    localparam int POS_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SAMPLES);

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic             in_ep_reg,    in_ep_next;
    logic [POS_W-1:0] start_reg,    start_next;
    category_t        prev_cat_reg, prev_cat_next;
    logic             drop_reg,     drop_next;
    logic [CNT_W-1:0] ep_cnt_reg,   ep_cnt_next;
    logic [CNT_W-1:0] drop_cnt_reg, drop_cnt_next;

    category_t        cat;
    logic             closed;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] c_start;
    logic [POS_W-1:0] c_end;
    logic             c_drop;

    always_comb
    begin
        cat = level_category(level, cfg);
        pos = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

        in_ep_next    = in_ep_reg;
        start_next    = start_reg;
        drop_next     = drop_reg;
        ep_cnt_next   = ep_cnt_reg;
        drop_cnt_next = drop_cnt_reg;
        closed        = 1'b0;
        c_start       = '0;
        c_end         = '0;
        c_drop        = 1'b0;

        if (cat != CAT_NONE)
        begin
            if (!in_ep_reg)
            begin
                in_ep_next = 1'b1;
                start_next = pos;
                drop_next  = (cat < prev_cat_reg);
            end
            else if (cat < prev_cat_reg)
            begin
                drop_next = 1'b1;
            end
            if (last)
            begin
                closed  = 1'b1;
                c_start = start_next;
                c_end   = pos;
                c_drop  = drop_next;
            end
        end
        else if (in_ep_reg)
        begin
            // low sample ends the episode at the previous position
            closed  = 1'b1;
            c_start = start_reg;
            c_end   = pos_reg;
            c_drop  = drop_reg;
        end

        if (closed)
        begin
            in_ep_next = 1'b0;
            drop_next  = 1'b0;
            if (ep_cnt_reg < COUNT_LIMIT)
            begin
                ep_cnt_next = ep_cnt_reg + 1'b1;
            end
            if (c_drop && (drop_cnt_reg < COUNT_LIMIT))
            begin
                drop_cnt_next = drop_cnt_reg + 1'b1;
            end
        end

        has_result                = closed | last;
        result.episode_valid      = closed;
        result.start_position     = POS_OUT_W'(c_start);
        result.end_position       = POS_OUT_W'(c_end);
        result.category_dropped   = c_drop;
        result.episode_total      = ep_cnt_next;
        result.drop_episode_total = drop_cnt_next;
        result.sequence_done      = last;

        pos_next      = pos;
        prev_cat_next = cat;
        if (last)
        begin
            // end of sequence: clear everything for the next one
            pos_next      = '0;
            in_ep_next    = 1'b0;
            start_next    = '0;
            prev_cat_next = CAT_NONE;
            drop_next     = 1'b0;
            ep_cnt_next   = '0;
            drop_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            in_ep_reg    <= 1'b0;
            start_reg    <= '0;
            prev_cat_reg <= CAT_NONE;
            drop_reg     <= 1'b0;
            ep_cnt_reg   <= '0;
            drop_cnt_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg      <= pos_next;
            in_ep_reg    <= in_ep_next;
            start_reg    <= start_next;
            prev_cat_reg <= prev_cat_next;
            drop_reg     <= drop_next;
            ep_cnt_reg   <= ep_cnt_next;
            drop_cnt_reg <= drop_cnt_next;
        end
    end

endmodule

### rtl/let_checker.sv
// Port-level checks for the level episode tracker, bound to the top level.
// Depends on let_pkg and level_episode_tracker.
module let_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [let_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);

    // hold a stalled result transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result transfer changed");

    // a result without a closed episode only comes with the last sample
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty result outside end of sequence");

    // an empty result carries zero positions and no drop
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[30:0] == 31'd0))
        else $error("empty result carries episode fields");

    // drop episodes are a subset of all episodes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[58:45] <= m_axis_tdata[44:31]))
        else $error("drop episode total exceeds episode total");

    // a free result side never holds off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while result side is ready");

endmodule

bind level_episode_tracker let_checker u_let_checker (.*);
